// ----- sv/fte_pkg.sv -----
// fte_pkg: shared types and constants for the flow table lookup block
// used by fte_ctrl, fte_dp and flow_table_find_or_evict; no dependencies
package fte_pkg;

  // table geometry
  localparam int SESSION_ENTRIES = 32;
  localparam int IDX_W           = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
  localparam int CNT_W           = $clog2(SESSION_ENTRIES + 1);

  // field widths
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int TIME_W    = 32;
  localparam int ENTRY_IDX_W = 5;
  localparam int OUTCOME_W = 2;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OC_HIT       = 2'd0;
  localparam logic [OUTCOME_W-1:0] OC_NEW_FREE  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OC_NEW_EVICT = 2'd2;

  // input item
  typedef struct packed {
    logic [ADDR_W-1:0] source_ip;
    logic [ADDR_W-1:0] dest_ip;
    logic [PORT_W-1:0] source_port;
    logic [PORT_W-1:0] dest_port;
    logic              is_response;
    logic [TIME_W-1:0] now_seconds;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [OUTCOME_W-1:0]   outcome;
  } out_item_t;

  // one stored session
  typedef struct packed {
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   dst_addr;
    logic [2*PORT_W-1:0] port_pair;
    logic [TIME_W-1:0]   last_seen;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } fte_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } fte_sts_t;

endpackage

// ----- sv/flow_table_find_or_evict.sv -----
// flow_table_find_or_evict: top level, joins the sequencer and the datapath
// depends on fte_pkg, fte_ctrl, fte_dp
//
// Session table lookup with oldest-entry eviction. Each accepted transfer carries
// a four-tuple, a direction flag and the time in seconds; response tuples are
// swapped into request order. The table (SESSION_ENTRIES entries, single-port
// memory) is read one entry per cycle, and a new transfer is taken only after the
// previous lookup has committed its entry and result; a waiting result only
// delays the table update of the next lookup. Hit, first free entry, else the
// entry with the largest wrapped age (lowest index on ties). Reset clears the
// per-entry valid bits at once, no clearing pass.
module flow_table_find_or_evict
  import fte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  fte_cmd_t cmd;
  fte_sts_t sts;

  fte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fte_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/fte_ctrl.sv -----
// fte_ctrl: lookup sequencer, walks the session table one entry per cycle
// depends on fte_pkg
module fte_ctrl
  import fte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fte_sts_t sts,
  output fte_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // only idle takes a new transfer
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.start   = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt_r[IDX_W-1:0];
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r < CNT_W'(SESSION_ENTRIES)) begin
          cmd.rd_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          // last compare is being taken this cycle
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- sv/fte_dp.sv -----
// fte_dp: key register, session table memory, scan trackers and result register
// depends on fte_pkg
module fte_dp
  import fte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  fte_cmd_t  cmd,
  output fte_sts_t  sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // lookup key in request order
  logic [ADDR_W-1:0]   key_src_r;
  logic [ADDR_W-1:0]   key_dst_r;
  logic [2*PORT_W-1:0] key_port_r;
  logic [TIME_W-1:0]   now_r;

  // table storage
  entry_t                    mem [SESSION_ENTRIES];
  logic [SESSION_ENTRIES-1:0] valid_r;

  // compare stage
  entry_t           rd_q_r;
  logic             chk_valid_r;
  logic [IDX_W-1:0] chk_idx_r;

  // scan trackers
  logic              hit_found_r, free_found_r;
  logic [IDX_W-1:0]  hit_idx_r, free_idx_r, old_idx_r;
  logic [TIME_W-1:0] oldest_r;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic                 chk_entry_valid;
  logic                 chk_match;
  logic [TIME_W-1:0]    age;
  logic [IDX_W-1:0]     slot;
  logic [OUTCOME_W-1:0] outcome;
  entry_t               wr_entry;

  // latch the key, swapped for the response direction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_r <= in_data.now_seconds;
      if (in_data.is_response) begin
        key_src_r  <= in_data.dest_ip;
        key_dst_r  <= in_data.source_ip;
        key_port_r <= {in_data.dest_port, in_data.source_port};
      end else begin
        key_src_r  <= in_data.source_ip;
        key_dst_r  <= in_data.dest_ip;
        key_port_r <= {in_data.source_port, in_data.dest_port};
      end
    end
  end

  // table read, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r <= mem[cmd.rd_addr];
    end
    chk_idx_r <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else begin
      chk_valid_r <= cmd.rd_en;
    end
  end

  // compare against the entry just read
  assign chk_entry_valid = valid_r[chk_idx_r];
  assign chk_match = chk_entry_valid && (rd_q_r.src_addr == key_src_r) &&
                     (rd_q_r.dst_addr == key_dst_r) && (rd_q_r.port_pair == key_port_r);
  assign age = now_r - rd_q_r.last_seen;

  // trackers: first hit, first free, oldest with lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.start) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (chk_valid_r) begin
      if (chk_match && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (!chk_entry_valid && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      oldest_r  <= '0;
      old_idx_r <= '0;
    end else if (chk_valid_r) begin
      if (chk_match && !hit_found_r) begin
        hit_idx_r <= chk_idx_r;
      end
      if (!chk_entry_valid && !free_found_r) begin
        free_idx_r <= chk_idx_r;
      end
      if (age > oldest_r) begin
        oldest_r  <= age;
        old_idx_r <= chk_idx_r;
      end
    end
  end

  // pick the slot and outcome
  always_comb begin
    if (hit_found_r) begin
      slot    = hit_idx_r;
      outcome = OC_HIT;
    end else if (free_found_r) begin
      slot    = free_idx_r;
      outcome = OC_NEW_FREE;
    end else begin
      slot    = old_idx_r;
      outcome = OC_NEW_EVICT;
    end
  end

  // on a hit the key is unchanged, so one write form covers every outcome
  assign wr_entry = '{src_addr: key_src_r, dst_addr: key_dst_r,
                      port_pair: key_port_r, last_seen: now_r};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[slot] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      valid_r[slot] <= 1'b1;
    end
  end

  // result register, holds until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.entry_index <= ENTRY_IDX_W'(slot);
      out_data_r.outcome     <= outcome;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // checks
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit while the result register is still held");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && valid_r[$past(slot)])
    else $error("committed entry or result not marked valid");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && hit_found_r |-> valid_r[hit_idx_r])
    else $error("hit reported on an empty entry");

  a_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !chk_valid_r && !cmd.rd_en)
    else $error("new lookup started while a compare is in flight");

endmodule

// ----- bench/flow_table_checker.sv -----
`timescale 1ns / 100ps
// flow_table_checker: watches both channels of flow_table_find_or_evict, predicts each
// lookup from a shadow session table and compares results; depends on fte_pkg
module flow_table_checker
  import fte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        results_due,
  output int        mismatch_count
);

  // shadow copy of the session table
  entry_t    shadow_flows [SESSION_ENTRIES];
  logic      shadow_live  [SESSION_ENTRIES];
  out_item_t due_results [$];

  // find the session for one packet, allocate or evict on a miss
  function automatic out_item_t lookup_session(input in_item_t pkt);
    logic [ADDR_W-1:0]    key_src;
    logic [ADDR_W-1:0]    key_dst;
    logic [2*PORT_W-1:0]  key_ports;
    logic [TIME_W-1:0]    age;
    logic [TIME_W-1:0]    oldest_age;
    logic [OUTCOME_W-1:0] verdict;
    int                   slot;
    out_item_t            res;
    // response packets are folded back into request order
    if (pkt.is_response) begin
      key_src   = pkt.dest_ip;
      key_dst   = pkt.source_ip;
      key_ports = {pkt.dest_port, pkt.source_port};
    end else begin
      key_src   = pkt.source_ip;
      key_dst   = pkt.dest_ip;
      key_ports = {pkt.source_port, pkt.dest_port};
    end
    // live match, lowest index first
    slot = -1;
    for (int k = 0; k < SESSION_ENTRIES; k++) begin
      if (slot < 0 && shadow_live[k] && shadow_flows[k].src_addr == key_src &&
          shadow_flows[k].dst_addr == key_dst && shadow_flows[k].port_pair == key_ports)
        slot = k;
    end
    if (slot >= 0) begin
      shadow_flows[slot].last_seen = pkt.now_seconds;
      verdict = OC_HIT;
    end else begin
      // first free entry
      for (int k = 0; k < SESSION_ENTRIES; k++) begin
        if (slot < 0 && !shadow_live[k])
          slot = k;
      end
      if (slot >= 0) begin
        verdict = OC_NEW_FREE;
      end else begin
        // largest wrapped age, strict compare keeps the lowest index on ties
        oldest_age = '0;
        slot = 0;
        for (int k = 0; k < SESSION_ENTRIES; k++) begin
          age = pkt.now_seconds - shadow_flows[k].last_seen;
          if (age > oldest_age) begin
            oldest_age = age;
            slot = k;
          end
        end
        verdict = OC_NEW_EVICT;
      end
      shadow_live[slot]            = 1'b1;
      shadow_flows[slot].src_addr  = key_src;
      shadow_flows[slot].dst_addr  = key_dst;
      shadow_flows[slot].port_pair = key_ports;
      shadow_flows[slot].last_seen = pkt.now_seconds;
    end
    res.entry_index = ENTRY_IDX_W'(slot);
    res.outcome     = verdict;
    return res;
  endfunction

  // sample both channels at the clock edge
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < SESSION_ENTRIES; k++) begin
        shadow_live[k]  = 1'b0;
        shadow_flows[k] = '0;
      end
      due_results.delete();
      mismatch_count = 0;
      results_due <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected: entry_index %0d outcome %0d",
                   $time, out_data.entry_index, out_data.outcome);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = due_results.pop_front();
          if (out_data.entry_index !== want.entry_index) begin
            $display("%0t: entry_index expected %0d actual %0d",
                     $time, want.entry_index, out_data.entry_index);
            mismatch_count = mismatch_count + 1;
          end
          if (out_data.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d",
                     $time, want.outcome, out_data.outcome);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      // input transfer feeds the predictor
      if (in_valid && !in_stall)
        due_results.push_back(lookup_session(in_data));
      results_due <= due_results.size();
    end
  end

endmodule

// ----- bench/tb_flow_table_find_or_evict.sv -----
`timescale 1ns / 100ps
// tb_flow_table_find_or_evict: stimulus and verdict for the flow table lookup block
// depends on fte_pkg, flow_table_find_or_evict and flow_table_checker
module tb_flow_table_find_or_evict;
  import fte_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int ITEM_TARGET = 650;
  localparam int LONG_HOLD   = 400;
  localparam int POOL_MAX    = 48;

  logic      clk          = 1'b0;
  logic      rst_n        = 1'b0;
  logic      in_valid     = 1'b0;
  in_item_t  in_data      = '0;
  logic      out_stall    = 1'b0;
  logic      hold_request = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        results_due;
  int        mismatch_count;

  int          sent_count = 0;
  logic        no_gaps    = 1'b0;
  logic [31:0] clock_s;
  in_item_t    flow_pool [$];

  flow_table_find_or_evict dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  flow_table_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // hard stop
  initial begin
    #(600000 * CLK_PERIOD);
    $display("tb_flow_table_find_or_evict NOT OK");
    $finish;
  end

  // wire-order packet for a request-order key
  function automatic in_item_t make_packet(input in_item_t key, input logic resp,
                                           input logic [31:0] now);
    in_item_t pkt;
    pkt = key;
    if (resp) begin
      pkt.source_ip   = key.dest_ip;
      pkt.dest_ip     = key.source_ip;
      pkt.source_port = key.dest_port;
      pkt.dest_port   = key.source_port;
    end
    pkt.is_response = resp;
    pkt.now_seconds = now;
    return pkt;
  endfunction

  function automatic in_item_t random_flow();
    in_item_t key;
    key.source_ip   = $urandom;
    key.dest_ip     = $urandom;
    key.source_port = 16'($urandom);
    key.dest_port   = 16'($urandom);
    key.is_response = 1'b0;
    key.now_seconds = '0;
    return key;
  endfunction

  // one input transfer, preceded by a random gap
  task automatic send_lookup(input in_item_t pkt);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60)
      gap = 0;
    else if (r < 90)
      gap = $urandom_range(1, 3);
    else if (r < 97)
      gap = $urandom_range(4, 12);
    else
      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // fill the table with fresh flows at one time, then force evictions on equal ages
  task automatic fill_and_tie(input logic [31:0] base_t);
    in_item_t key;
    for (int k = 0; k < SESSION_ENTRIES + 2; k++) begin
      key = random_flow();
      flow_pool.push_back(key);
      if (flow_pool.size() > POOL_MAX) void'(flow_pool.pop_front());
      send_lookup(make_packet(key, 1'($urandom_range(0, 1)), base_t));
    end
    // every age equal and non-zero
    send_lookup(make_packet(random_flow(), 1'b0, base_t + 32'd7));
    // wrapped age against a fresh entry
    send_lookup(make_packet(random_flow(), 1'b1, base_t + 32'd40));
    clock_s = base_t + 32'd41;
  endtask

  // receiver: random stalls, one long hold on request
  initial begin : receiver
    bit hold_served;
    int r;
    int open_len;
    int stall_len;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        open_len  = (r < 90) ? $urandom_range(1, 8) : $urandom_range(100, 300);
        r = $urandom_range(0, 99);
        stall_len = (r < 85) ? $urandom_range(1, 3) :
                    (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
        out_stall <= 1'b0;
        repeat (open_len) @(posedge clk);
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    in_item_t zero_key;
    in_item_t ones_key;
    in_item_t base_key;
    in_item_t swap_key;
    in_item_t pkt;
    int       r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, direction swap, empty entries that must not match
    zero_key = '0;
    ones_key = '1;
    ones_key.is_response = 1'b0;
    base_key = '0;
    base_key.source_ip   = 32'h0A00_0001;
    base_key.dest_ip     = 32'hC0A8_0102;
    base_key.source_port = 16'h8001;
    base_key.dest_port   = 16'h0050;
    swap_key = make_packet(base_key, 1'b1, '0);
    swap_key.is_response = 1'b0;
    flow_pool.push_back(zero_key);
    flow_pool.push_back(ones_key);
    flow_pool.push_back(base_key);
    flow_pool.push_back(swap_key);

    // zero tuple against a table whose valid bits are cleared by reset
    send_lookup(make_packet(zero_key, 1'b0, 32'd0));
    send_lookup(make_packet(zero_key, 1'b1, 32'd0));
    send_lookup(make_packet(ones_key, 1'b0, 32'hFFFF_FFFF));
    send_lookup(make_packet(ones_key, 1'b1, 32'hFFFF_FFFF));
    send_lookup(make_packet(base_key, 1'b0, 32'd100));
    send_lookup(make_packet(base_key, 1'b1, 32'd101));
    // reversed tuple sent as a request is a separate session
    send_lookup(make_packet(swap_key, 1'b0, 32'd102));
    // request-order wire fields flagged as response fold onto the reversed session
    pkt = make_packet(base_key, 1'b0, 32'd103);
    pkt.is_response = 1'b1;
    send_lookup(pkt);
    // single field differences
    pkt = make_packet(base_key, 1'b0, 32'd104);
    pkt.source_port = pkt.source_port ^ 16'h0001;
    send_lookup(pkt);
    pkt = make_packet(base_key, 1'b0, 32'd105);
    pkt.dest_ip = pkt.dest_ip ^ 32'h8000_0000;
    send_lookup(pkt);
    pkt = make_packet(base_key, 1'b0, 32'd106);
    pkt.dest_port = pkt.dest_port ^ 16'h8000;
    send_lookup(pkt);
    send_lookup(make_packet(zero_key, 1'b0, 32'h8000_0000));
    drain_results();

    // full table with tied ages, once plain and once across the time wrap
    fill_and_tie(32'h0001_0000);
    fill_and_tie(32'hFFFF_FFE8);
    drain_results();

    // random traffic: mostly revisited and new flows, some noise
    clock_s = 32'hFFFF_FF00;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count == 200)
        hold_request <= 1'b1;
      no_gaps = (sent_count >= 300 && sent_count < 360);
      r = $urandom_range(0, 49);
      if (r == 0)
        clock_s = $urandom;
      else
        clock_s = clock_s + 32'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 50) begin
        pkt = make_packet(flow_pool[$urandom_range(0, flow_pool.size() - 1)],
                          1'($urandom_range(0, 1)), clock_s);
      end else if (r < 88) begin
        pkt = random_flow();
        flow_pool.push_back(pkt);
        if (flow_pool.size() > POOL_MAX) void'(flow_pool.pop_front());
        pkt = make_packet(pkt, 1'($urandom_range(0, 1)), clock_s);
      end else begin
        pkt = make_packet(random_flow(), 1'($urandom_range(0, 1)), $urandom);
      end
      send_lookup(pkt);
      if (sent_count % 150 == 0)
        drain_results();
    end

    // wait out the tail
    drain_results();
    repeat (2 * (SESSION_ENTRIES + 3)) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_flow_table_find_or_evict OK");
    else
      $display("tb_flow_table_find_or_evict NOT OK");
    $finish;
  end

endmodule

// ----- flow_table_find_or_evict.f -----
sv/fte_pkg.sv
sv/fte_ctrl.sv
sv/fte_dp.sv
sv/flow_table_find_or_evict.sv
bench/flow_table_checker.sv
bench/tb_flow_table_find_or_evict.sv
